// File: rtl/core/triangle_face_normal_unit_defines.svh
// Assertion macros shared by the checker of the triangle face normal unit.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef TRIANGLE_FACE_NORMAL_UNIT_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_UNIT_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define TFN_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tfn check failed");

// The consequent holds in the cycle after the antecedent.
`define TFN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tfn check failed");

`endif

// File: rtl/core/tfn_pkg.sv
// Package of the triangle face normal unit: state types, result struct and constants.
// It has no dependencies; the top level and the normal unit use it.
package tfn_pkg;

    localparam int INDEX_W     = 12;
    localparam int FIELD_W     = 16;
    localparam int NORM_FRAC   = 14;
    localparam int TARGET_BITS = 30;
    localparam int QUOT_W      = NORM_FRAC + 2;
    localparam int DIV_W       = 48;
    localparam int ROOT_W      = 64;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_FACE  = 1'b1;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_RD0   = 8'b0000_0100,
        S_RD1   = 8'b0000_1000,
        S_RD2   = 8'b0001_0000,
        S_RD3   = 8'b0010_0000,
        S_NORM  = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } top_state_t;

    typedef enum logic [9:0] {
        N_IDLE  = 10'b00_0000_0001,
        N_CROSS = 10'b00_0000_0010,
        N_MAX   = 10'b00_0000_0100,
        N_LEN   = 10'b00_0000_1000,
        N_SCALE = 10'b00_0001_0000,
        N_SQ    = 10'b00_0010_0000,
        N_ROOT  = 10'b00_0100_0000,
        N_DLD   = 10'b00_1000_0000,
        N_DIV   = 10'b01_0000_0000,
        N_FIN   = 10'b10_0000_0000
    } norm_state_t;

    typedef struct packed {
        logic                           done;
        logic                           degen;
        logic [2:0][FIELD_W-1:0]        n;
    } norm_res_t;

endpackage

// File: rtl/core/tfn_norm.sv
// Normal unit: cross product on a shared multiplier, scaling, integer square root
// and restoring division to a Q1.14 unit normal. Depends on tfn_pkg.
module tfn_norm #(
    parameter int COORD_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [((COORD_BITS < 16) ? COORD_BITS : 16):0] e1 [3],
    input  logic signed [((COORD_BITS < 16) ? COORD_BITS : 16):0] e2 [3],
    output tfn_pkg::norm_res_t      res
);

    localparam int CW   = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int DW   = CW + 1;
    localparam int PW   = 2 * DW;
    localparam int XW   = PW + 1;
    localparam int MW   = PW;
    localparam int BLW  = $clog2(MW + 1);
    localparam int SW   = tfn_pkg::TARGET_BITS + 1;
    localparam int SCW  = (MW + 1 > SW) ? MW + 1 : SW;
    localparam int QW   = tfn_pkg::QUOT_W;
    localparam int DVW  = tfn_pkg::DIV_W;
    localparam int RW   = tfn_pkg::ROOT_W;
    localparam int FW   = tfn_pkg::FIELD_W;

    tfn_pkg::norm_state_t state_reg, state_next;

    logic signed [DW-1:0] e1_reg [3];
    logic signed [DW-1:0] e2_reg [3];
    logic [2:0]           step_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] first_reg;
    logic signed [XW-1:0] cr_reg [3];
    logic [MW-1:0]        mg_reg [3];
    logic [MW-1:0]        m_reg;
    logic [BLW-1:0]       blen_reg;
    logic [SW-1:0]        sc_reg [3];
    logic [2*SW-1:0]      sqp_reg;
    logic [RW-1:0]        sum_reg;
    logic [RW-1:0]        rem_reg;
    logic [RW-1:0]        root_reg;
    logic [RW-1:0]        bit_reg;
    logic [DVW-1:0]       drem_reg;
    logic [DVW-1:0]       dsh_reg;
    logic [QW-1:0]        q_reg;
    logic [3:0]           qcnt_reg;
    logic [1:0]           ci_reg;
    logic [FW-1:0]        n_reg [3];
    logic                 degen_reg;

    logic signed [DW-1:0] ma, mb;
    logic signed [PW-1:0] prod_c;
    logic [2:0]           kstep;
    logic [MW-1:0]        mg_c [3];
    logic [MW-1:0]        max_c;
    logic [5:0]           lsh, rsh;
    logic [SCW-1:0]       sc_c [3];
    logic [RW-1:0]        trial;
    logic                 root_ge;
    logic [31:0]          lroot;
    logic                 div_ge;
    logic [QW-1:0]        q_next;
    logic [FW-1:0]        qmag;

    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (step_reg)
            3'd0:
            begin
                ma = e1_reg[1];
                mb = e2_reg[2];
            end
            3'd1:
            begin
                ma = e1_reg[2];
                mb = e2_reg[1];
            end
            3'd2:
            begin
                ma = e2_reg[0];
                mb = e1_reg[2];
            end
            3'd3:
            begin
                ma = e2_reg[2];
                mb = e1_reg[0];
            end
            3'd4:
            begin
                ma = e2_reg[1];
                mb = e1_reg[0];
            end
            3'd5:
            begin
                ma = e2_reg[0];
                mb = e1_reg[1];
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign prod_c = PW'(ma) * PW'(mb);
    assign kstep  = step_reg - 3'd1;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mg_c[i] = cr_reg[i][XW-1] ? MW'(-cr_reg[i]) : MW'(cr_reg[i]);
        end
        max_c = mg_c[0];
        if (mg_c[1] > max_c)
        begin
            max_c = mg_c[1];
        end
        if (mg_c[2] > max_c)
        begin
            max_c = mg_c[2];
        end
    end

    always_comb
    begin
        lsh = 6'(tfn_pkg::TARGET_BITS) - 6'(blen_reg);
        rsh = 6'(blen_reg) - 6'(tfn_pkg::TARGET_BITS);
        for (int i = 0; i < 3; i++)
        begin
            priority if (6'(blen_reg) < 6'(tfn_pkg::TARGET_BITS))
            begin
                sc_c[i] = SCW'(mg_reg[i]) << lsh;
            end
            else if (6'(blen_reg) > 6'(tfn_pkg::TARGET_BITS))
            begin
                sc_c[i] = (SCW'(mg_reg[i]) + (SCW'(1) << (rsh - 6'd1))) >> rsh;
            end
            else
            begin
                sc_c[i] = SCW'(mg_reg[i]);
            end
        end
    end

    assign trial   = root_reg + bit_reg;
    assign root_ge = rem_reg >= trial;
    assign lroot   = root_reg[31:0];
    assign div_ge  = drem_reg >= dsh_reg;
    assign q_next  = {q_reg[QW-2:0], div_ge};
    assign qmag    = FW'(q_next);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tfn_pkg::N_IDLE:
            begin
                if (start)
                begin
                    state_next = tfn_pkg::N_CROSS;
                end
            end
            tfn_pkg::N_CROSS:
            begin
                if (step_reg == 3'd6)
                begin
                    state_next = tfn_pkg::N_MAX;
                end
            end
            tfn_pkg::N_MAX:
            begin
                state_next = (max_c == '0) ? tfn_pkg::N_FIN : tfn_pkg::N_LEN;
            end
            tfn_pkg::N_LEN:
            begin
                if (m_reg == '0)
                begin
                    state_next = tfn_pkg::N_SCALE;
                end
            end
            tfn_pkg::N_SCALE:
            begin
                state_next = tfn_pkg::N_SQ;
            end
            tfn_pkg::N_SQ:
            begin
                if (step_reg == 3'd3)
                begin
                    state_next = tfn_pkg::N_ROOT;
                end
            end
            tfn_pkg::N_ROOT:
            begin
                if (bit_reg[0])
                begin
                    state_next = tfn_pkg::N_DLD;
                end
            end
            tfn_pkg::N_DLD:
            begin
                state_next = tfn_pkg::N_DIV;
            end
            tfn_pkg::N_DIV:
            begin
                if (qcnt_reg == 4'(QW - 1))
                begin
                    state_next = (ci_reg == 2'd2) ? tfn_pkg::N_FIN : tfn_pkg::N_DLD;
                end
            end
            tfn_pkg::N_FIN:
            begin
                state_next = tfn_pkg::N_IDLE;
            end
            default:
            begin
                state_next = tfn_pkg::N_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tfn_pkg::N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            tfn_pkg::N_IDLE:
            begin
                e1_reg   <= e1;
                e2_reg   <= e2;
                step_reg <= '0;
            end
            tfn_pkg::N_CROSS:
            begin
                prod_reg <= prod_c;
                step_reg <= step_reg + 3'd1;
                if (step_reg != 3'd0)
                begin
                    if (!kstep[0])
                    begin
                        first_reg <= prod_reg;
                    end
                    else
                    begin
                        cr_reg[kstep[2:1]] <= XW'(first_reg) - XW'(prod_reg);
                    end
                end
            end
            tfn_pkg::N_MAX:
            begin
                mg_reg    <= mg_c;
                m_reg     <= max_c;
                blen_reg  <= '0;
                degen_reg <= (max_c == '0);
                for (int i = 0; i < 3; i++)
                begin
                    n_reg[i] <= '0;
                end
            end
            tfn_pkg::N_LEN:
            begin
                if (m_reg != '0)
                begin
                    m_reg    <= m_reg >> 1;
                    blen_reg <= blen_reg + BLW'(1);
                end
            end
            tfn_pkg::N_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sc_reg[i] <= SW'(sc_c[i]);
                end
                step_reg <= '0;
                sum_reg  <= '0;
            end
            tfn_pkg::N_SQ:
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg != 3'd3)
                begin
                    sqp_reg <= (2*SW)'(sc_reg[step_reg[1:0]]) *
                               (2*SW)'(sc_reg[step_reg[1:0]]);
                end
                if (step_reg != 3'd0)
                begin
                    sum_reg <= sum_reg + RW'(sqp_reg);
                end
                if (step_reg == 3'd3)
                begin
                    rem_reg  <= sum_reg + RW'(sqp_reg);
                    root_reg <= '0;
                    bit_reg  <= RW'(1) << (RW - 2);
                end
            end
            tfn_pkg::N_ROOT:
            begin
                if (root_ge)
                begin
                    rem_reg  <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                ci_reg  <= '0;
            end
            tfn_pkg::N_DLD:
            begin
                drem_reg <= (DVW'(sc_reg[ci_reg]) << (tfn_pkg::NORM_FRAC + 1)) + DVW'(lroot);
                dsh_reg  <= DVW'({lroot, 1'b0}) << (QW - 1);
                q_reg    <= '0;
                qcnt_reg <= '0;
            end
            tfn_pkg::N_DIV:
            begin
                if (div_ge)
                begin
                    drem_reg <= drem_reg - dsh_reg;
                end
                dsh_reg  <= dsh_reg >> 1;
                q_reg    <= q_next;
                qcnt_reg <= qcnt_reg + 4'd1;
                if (qcnt_reg == 4'(QW - 1))
                begin
                    n_reg[ci_reg] <= cr_reg[ci_reg][XW-1] ? (FW'(0) - qmag) : qmag;
                    ci_reg        <= ci_reg + 2'd1;
                end
            end
            tfn_pkg::N_FIN:
            begin
                step_reg <= '0;
            end
            default:
            begin
                step_reg <= '0;
            end
        endcase
    end

    assign res.done  = (state_reg == tfn_pkg::N_FIN);
    assign res.degen = degen_reg;
    assign res.n[0]  = n_reg[0];
    assign res.n[1]  = n_reg[1];
    assign res.n[2]  = n_reg[2];

endmodule

// File: rtl/core/triangle_face_normal_unit.sv
// Triangle face normal unit: vertex store, face fetch sequencer and result register.
// Depends on tfn_pkg and instantiates tfn_norm.
//
// Use: the req channel carries write items (req_type low) that store one vertex
// at vertex_slot, and face items (req_type high) that name three stored corners.
// A write item gives no result; a face item gives three items on the res channel,
// one per corner in the order a, b, c, the third with last_corner set.
// A face item reads its three corners from the store one after another, then the
// normal unit works through start, cross product, largest magnitude, bit length,
// scaling, squares, root, three divisions and finish; a degenerate face goes from
// the largest magnitude straight to finish, and a bad face skips the unit.
// The three results then leave one per cycle while res_stall is low.
// After reset the written map is cleared, one entry per cycle, with req_stall
// held high. While res_stall is high the result item waits in the output
// register; the next item is taken on the req channel once the face has been
// handed to that register.
module triangle_face_normal_unit #(
    parameter int VERTEX_DEPTH = 4096,
    parameter int COORD_BITS   = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic               req_type,
    input  logic [11:0]        vertex_slot,
    input  logic signed [15:0] coord_x,
    input  logic signed [15:0] coord_y,
    input  logic signed [15:0] coord_z,
    input  logic [11:0]        corner_a,
    input  logic [11:0]        corner_b,
    input  logic [11:0]        corner_c,
    output logic               res_valid,
    input  logic               res_stall,
    output logic signed [15:0] out_x,
    output logic signed [15:0] out_y,
    output logic signed [15:0] out_z,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z,
    output logic               last_corner,
    output logic               degenerate,
    output logic               bad_index
);

    localparam int CW  = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int DW  = CW + 1;
    localparam int VW  = 3 * CW;
    localparam int AW  = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam int IW  = tfn_pkg::INDEX_W;
    localparam int XAW = (AW > IW) ? AW : IW;
    localparam int FW  = tfn_pkg::FIELD_W;

    tfn_pkg::top_state_t state_reg, state_next;

    logic [AW-1:0]        clr_cnt_reg;
    logic [AW-1:0]        cor_reg [3];
    logic [2:0]           inr_reg;
    logic [2:0]           ok_reg;
    logic signed [CW-1:0] v_reg [3][3];
    logic [FW-1:0]        nrm_reg [3];
    logic                 degen_reg;
    logic                 bad_reg;
    logic                 start_reg;
    logic [1:0]           emit_reg;
    logic                 res_valid_reg;
    logic signed [FW-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic signed [FW-1:0] nx_reg, ny_reg, nz_reg;
    logic                 last_reg, odegen_reg, obad_reg;

    logic [VW-1:0]        vstore [VERTEX_DEPTH];
    logic                 wmap [VERTEX_DEPTH];
    logic [VW-1:0]        vdata_reg;
    logic                 wbit_reg;

    logic                 accept;
    logic                 do_write;
    logic                 do_face;
    logic [XAW-1:0]       slot_ext, a_ext, b_ext, c_ext;
    logic [AW-1:0]        w_addr;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        map_addr;
    logic                 map_we;
    logic                 map_bit;
    logic                 clearing;
    logic [1:0]           cap_idx;
    logic                 ok_now;
    logic                 bad_now;
    logic                 out_load;

    logic signed [DW-1:0] e1 [3];
    logic signed [DW-1:0] e2 [3];
    tfn_pkg::norm_res_t   nres;

    assign accept   = req_valid && !req_stall;
    assign do_face  = accept && (req_type == tfn_pkg::REQ_FACE);
    assign do_write = accept && (req_type == tfn_pkg::REQ_WRITE) &&
                      (32'(vertex_slot) < VERTEX_DEPTH);
    assign slot_ext = XAW'(vertex_slot);
    assign a_ext    = XAW'(corner_a);
    assign b_ext    = XAW'(corner_b);
    assign c_ext    = XAW'(corner_c);
    assign w_addr   = slot_ext[AW-1:0];
    assign clearing = (state_reg == tfn_pkg::S_CLEAR);
    assign map_we   = clearing || do_write;
    assign map_bit  = !clearing;
    assign map_addr = clearing ? clr_cnt_reg : w_addr;

    always_comb
    begin
        unique case (state_reg)
            tfn_pkg::S_RD0: rd_addr = cor_reg[0];
            tfn_pkg::S_RD1: rd_addr = cor_reg[1];
            default:        rd_addr = cor_reg[2];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            vstore[w_addr] <= {coord_x[CW-1:0], coord_y[CW-1:0], coord_z[CW-1:0]};
        end
        vdata_reg <= vstore[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            wmap[map_addr] <= map_bit;
        end
        wbit_reg <= wmap[rd_addr];
    end

    always_comb
    begin
        unique case (state_reg)
            tfn_pkg::S_RD1: cap_idx = 2'd0;
            tfn_pkg::S_RD2: cap_idx = 2'd1;
            default:        cap_idx = 2'd2;
        endcase
    end

    assign ok_now  = inr_reg[cap_idx] && wbit_reg;
    assign bad_now = !ok_reg[0] || !ok_reg[1] || !ok_now;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            e1[j] = DW'(v_reg[0][j]) - DW'(v_reg[1][j]);
            e2[j] = DW'(v_reg[0][j]) - DW'(v_reg[2][j]);
        end
    end

    tfn_norm #(
        .COORD_BITS(COORD_BITS)
    ) u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .e1    (e1),
        .e2    (e2),
        .res   (nres)
    );

    assign out_load = (state_reg == tfn_pkg::S_EMIT) && (!res_valid_reg || !res_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tfn_pkg::S_CLEAR:
            begin
                if (clr_cnt_reg == AW'(VERTEX_DEPTH - 1))
                begin
                    state_next = tfn_pkg::S_IDLE;
                end
            end
            tfn_pkg::S_IDLE:
            begin
                if (do_face)
                begin
                    state_next = tfn_pkg::S_RD0;
                end
            end
            tfn_pkg::S_RD0: state_next = tfn_pkg::S_RD1;
            tfn_pkg::S_RD1: state_next = tfn_pkg::S_RD2;
            tfn_pkg::S_RD2: state_next = tfn_pkg::S_RD3;
            tfn_pkg::S_RD3:
            begin
                state_next = bad_now ? tfn_pkg::S_EMIT : tfn_pkg::S_NORM;
            end
            tfn_pkg::S_NORM:
            begin
                if (nres.done)
                begin
                    state_next = tfn_pkg::S_EMIT;
                end
            end
            tfn_pkg::S_EMIT:
            begin
                if (out_load && (emit_reg == 2'd2))
                begin
                    state_next = tfn_pkg::S_IDLE;
                end
            end
            default: state_next = tfn_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tfn_pkg::S_CLEAR;
            clr_cnt_reg   <= '0;
            start_reg     <= 1'b0;
            emit_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            start_reg <= (state_reg == tfn_pkg::S_RD3) && !bad_now;
            if (out_load)
            begin
                res_valid_reg <= 1'b1;
                emit_reg      <= (emit_reg == 2'd2) ? 2'd0 : emit_reg + 2'd1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_face)
        begin
            cor_reg[0] <= a_ext[AW-1:0];
            cor_reg[1] <= b_ext[AW-1:0];
            cor_reg[2] <= c_ext[AW-1:0];
            inr_reg    <= {32'(corner_c) < VERTEX_DEPTH,
                           32'(corner_b) < VERTEX_DEPTH,
                           32'(corner_a) < VERTEX_DEPTH};
        end
        if ((state_reg == tfn_pkg::S_RD1) || (state_reg == tfn_pkg::S_RD2) ||
            (state_reg == tfn_pkg::S_RD3))
        begin
            ok_reg[cap_idx] <= ok_now;
            v_reg[cap_idx][0] <= ok_now ? vdata_reg[VW-1 -: CW] : '0;
            v_reg[cap_idx][1] <= ok_now ? vdata_reg[2*CW-1 -: CW] : '0;
            v_reg[cap_idx][2] <= ok_now ? vdata_reg[CW-1:0] : '0;
        end
        if (state_reg == tfn_pkg::S_RD3)
        begin
            bad_reg   <= bad_now;
            degen_reg <= 1'b0;
            for (int j = 0; j < 3; j++)
            begin
                nrm_reg[j] <= '0;
            end
        end
        if ((state_reg == tfn_pkg::S_NORM) && nres.done)
        begin
            degen_reg  <= nres.degen;
            nrm_reg[0] <= nres.n[0];
            nrm_reg[1] <= nres.n[1];
            nrm_reg[2] <= nres.n[2];
        end
        if (out_load)
        begin
            out_x_reg  <= FW'(v_reg[emit_reg][0]);
            out_y_reg  <= FW'(v_reg[emit_reg][1]);
            out_z_reg  <= FW'(v_reg[emit_reg][2]);
            nx_reg     <= nrm_reg[0];
            ny_reg     <= nrm_reg[1];
            nz_reg     <= nrm_reg[2];
            last_reg   <= (emit_reg == 2'd2);
            odegen_reg <= degen_reg;
            obad_reg   <= bad_reg;
        end
    end

    assign req_stall   = (state_reg != tfn_pkg::S_IDLE);
    assign res_valid   = res_valid_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_z       = out_z_reg;
    assign normal_x    = nx_reg;
    assign normal_y    = ny_reg;
    assign normal_z    = nz_reg;
    assign last_corner = last_reg;
    assign degenerate  = odegen_reg;
    assign bad_index   = obad_reg;

endmodule

// File: rtl/core/tfn_checker.sv
// Port-level checker of the triangle face normal unit, bound to the top level.
// Depends on triangle_face_normal_unit_defines.svh for its assertion macros.
`include "triangle_face_normal_unit_defines.svh"

module tfn_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic               res_valid,
    input logic               res_stall,
    input logic signed [15:0] out_x,
    input logic signed [15:0] normal_x,
    input logic signed [15:0] normal_y,
    input logic signed [15:0] normal_z,
    input logic               degenerate,
    input logic               bad_index
);

    // A stalled result item stays offered and unchanged.
    `TFN_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(out_x) && $stable(normal_x))

    // A degenerate face reports a zero normal.
    `TFN_ASSERT_SAME(a_degen_zero, res_valid && degenerate, normal_x == 16'sd0 && normal_y == 16'sd0 && normal_z == 16'sd0)

    // A face with a bad corner reports zero normal_x and normal_z and is never degenerate.
    `TFN_ASSERT_SAME(a_bad_zero, res_valid && bad_index, !degenerate && normal_x == 16'sd0 && normal_z == 16'sd0)

    // The written map is being cleared straight after reset, so no item is taken.
    `TFN_ASSERT_SAME(a_reset_clear, $rose(rst_n), req_stall)

endmodule

bind triangle_face_normal_unit tfn_checker u_tfn_checker (.*);
